// ===== sv/css_pkg.sv =====
// shared types and constants for the cocktail shaker sorter
package css_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } css_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic             last_out;
    logic             overflow;
  } css_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             drn;
    logic [VAL_W-1:0] new_val;
  } css_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } css_state_t;

endpackage

// ===== sv/css_cell.sv =====
// one cell of the sorting chain: holds one value, trades with its neighbors
module css_cell
  import css_pkg::*;
(
  input  logic             clk,
  input  css_ctrl_t        ctrl,
  input  logic             occ,
  input  logic             left_keep,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  output logic             keep,
  output logic [VAL_W-1:0] val
);

  logic [VAL_W-1:0] val_next;

  // an occupied cell whose value does not exceed the new one stays put
  assign keep = occ && (val <= ctrl.new_val);

  always_comb begin
    val_next = val;
    if (ctrl.ins) begin
      if (keep) begin
        val_next = val;
      end else if (left_keep) begin
        val_next = ctrl.new_val;
      end else begin
        val_next = left_val;
      end
    end else if (ctrl.drn) begin
      val_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== sv/cocktail_shaker_sorter_unit.sv =====
// top level of the cocktail shaker sorter: cell chain, fill count and drain control
//
// usage:
//   input channel: a transfer happens at a rising edge with start high and busy
//   low. item.value is one unsigned value of the batch, item.last closes it.
//   each value is placed into a sorted row of DEPTH cells as it arrives: every
//   cell compares its value with the new one in parallel and the row shifts one
//   place right past the insertion point; busy stays low while loading.
//   values beyond DEPTH in one batch are dropped and the batch is flagged.
//   output channel: after the closing transfer busy goes high and the row
//   shifts toward cell 0, one value per cycle. each result is shown for exactly
//   one cycle with strobe high; the receiver cannot stall it.
//   timing: a batch is first loaded in full and then drained; each result
//   passes the drain state and then the result register before strobe shows
//   it. the rate is set by the single shared insertion point at load and the
//   single output at drain.
//   overflow is high on every result of a batch that lost values.
//   reset: rst (synchronous, active high) empties the fill count, clears the
//   dropped flag, returns to loading and clears the strobe; the cell values are
//   not cleared, a cell beyond the fill count never reaches the output.
module cocktail_shaker_sorter_unit
  import css_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  css_in_t  item,
  output logic     strobe,
  output css_out_t result
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  css_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             dropped, dropped_next;
  css_ctrl_t        ctrl;
  logic             accept;
  logic             full;
  logic             emit;

  // chain wiring
  logic [DEPTH-1:0]  occ;
  logic [DEPTH-1:0]  keep;
  logic [VAL_W-1:0]  val [DEPTH];

  assign full   = (count == CNT_W'(DEPTH));
  assign accept = start && !busy;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  // next state and chain commands
  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    busy         = 1'b0;
    emit         = 1'b0;
    ctrl.ins     = 1'b0;
    ctrl.drn     = 1'b0;
    ctrl.new_val = item.value;
    case (state)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            ctrl.ins   = 1'b1;
            count_next = count + 1'b1;
          end
          if (item.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        busy       = 1'b1;
        emit       = 1'b1;
        ctrl.drn   = 1'b1;
        count_next = count - 1'b1;
        // final value leaves: batch done
        if (count == CNT_W'(1)) begin
          state_next   = ST_LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // row of cells, kept in ascending order from cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             lk;
    logic [VAL_W-1:0] lv;
    logic [VAL_W-1:0] rv;

    assign occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign lv = item.value;
    end else begin : g_inner
      assign lk = keep[i-1];
      assign lv = val[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign rv = val[i];
    end else begin : g_mid
      assign rv = val[i+1];
    end

    css_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[i]),
      .left_keep (lk),
      .left_val  (lv),
      .right_val (rv),
      .keep      (keep[i]),
      .val       (val[i])
    );
  end

  // result register: the strobe is control, the payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.sorted_value <= val[0];
      result.last_out     <= (count == CNT_W'(1));
      result.overflow     <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("drain with an empty row");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_close_drains: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.last |=> busy)
    else $error("closing transfer did not start the drain");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_out |-> !busy && count == '0)
    else $error("final result while the row still holds values");
`endif

endmodule
